// ===== rtl/core/nnis_pkg.sv =====
// Types and constants shared by the nearest-neighbor image scaler.
// Holds the input and result beat structs, op and register codes, and the divider step.
// No dependencies.
package nnis_pkg;

    localparam int DIM_W       = 9;
    localparam int ERR_W       = 10;
    localparam int COORD_W     = 8;
    localparam int PIXEL_W     = 32;
    localparam int CH_W        = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int DIV_STEPS   = 9;
    localparam int CNT_W       = 4;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_EMIT    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_CHANNELS   = 3'd4
    } reg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] load_col;
        logic [COORD_W-1:0] load_row;
        logic [PIXEL_W-1:0] pixel_value;
    } item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               end_of_row;
        logic               end_of_frame;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0] num;
        logic [DIM_W-1:0] rem;
    } div_t;

    // One restoring division step: quotient bits shift into num.
    function automatic div_t div_step(div_t cur, logic [DIM_W-1:0] den);
        logic [DIM_W:0] trial;
        div_t           nxt;
        trial = {cur.rem, cur.num[DIM_W-1]};
        if (trial >= {1'b0, den})
        begin
            nxt.num = {cur.num[DIM_W-2:0], 1'b1};
            nxt.rem = DIM_W'(trial - {1'b0, den});
        end
        else
        begin
            nxt.num = {cur.num[DIM_W-2:0], 1'b0};
            nxt.rem = trial[DIM_W-1:0];
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/core/nnis_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Used as the scaler frame store; no dependencies.
module nnis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== rtl/core/nearest_neighbor_image_scaler.sv =====
// Nearest-neighbor image scaler: frame store, Bresenham stepping and restart divider.
// Depends on nnis_pkg and nnis_ram.
//
// Load and emit beats may follow one another in every cycle while busy is low;
// an emit result appears on the result port in the cycle after its beat is accepted,
// as the frame store read is registered. A restart beat keeps busy high while
// a restoring divider per axis forms step and remainder for that axis,
// one quotient bit per cycle. Results are strobed for one cycle by result_valid and
// must be taken then. Configuration writes are always ready and take effect at the
// next restart (sizes) or at the next result (channel mask).
module nearest_neighbor_image_scaler #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  nnis_pkg::item_t                  item,
    output logic                             result_valid,
    output nnis_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nnis_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import nnis_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = MAX_CHANNELS * 8;
    localparam logic [DIM_W-1:0] W_LIMIT  = (MAX_WIDTH > 511) ? 9'd511 : DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_LIMIT  = (MAX_HEIGHT > 511) ? 9'd511 : DIM_W'(MAX_HEIGHT);
    localparam logic [CH_W-1:0]  CH_LIMIT = CH_W'(MAX_CHANNELS);

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                   logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Configuration registers
    logic [DIM_W-1:0] src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic [CH_W-1:0]  channels_reg;

    // Scan state
    state_t                   state_reg, state_next;
    logic [DIM_W-1:0]         frame_w_reg, frame_w_next, frame_h_reg, frame_h_next;
    logic [DIM_W-1:0]         src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [DIM_W-1:0]         out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic signed [ERR_W-1:0]  col_err_reg, col_err_next, row_err_reg, row_err_next;
    logic [DIM_W-1:0]         col_step_reg, col_step_next, row_step_reg, row_step_next;
    logic [DIM_W-1:0]         col_rem_reg, col_rem_next, row_rem_reg, row_rem_next;
    div_t                     div_col_reg, div_col_next, div_row_reg, div_row_next;
    logic [CNT_W-1:0]         div_cnt_reg, div_cnt_next;
    logic                     emit_reg, emit_next, eor_reg, eor_next, eof_reg, eof_next;

    logic                     accept;
    logic                     load_ok;
    logic                     eor, eof;
    logic [31:0]              load_addr, rd_col, rd_row, rd_addr;
    logic                     ram_en, ram_we;
    logic [AW-1:0]            ram_addr;
    logic [SW-1:0]            ram_rdata, pix_mask;
    logic [CH_W-1:0]          ch_eff;
    logic signed [ERR_W:0]    col_err_dec, row_err_dec;
    div_t                     div_col_step, div_row_step;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg == ST_DIVIDE);
    assign accept    = start && !busy;

    // Frame store access
    assign load_ok   = ({24'd0, item.load_col} < 32'(MAX_WIDTH))
                    && ({24'd0, item.load_row} < 32'(MAX_HEIGHT));
    assign load_addr = {24'd0, item.load_row} * 32'(MAX_WIDTH) + {24'd0, item.load_col};
    assign rd_col    = ({23'd0, src_col_reg} < 32'(MAX_WIDTH))
                     ? {23'd0, src_col_reg} : 32'(MAX_WIDTH - 1);
    assign rd_row    = ({23'd0, src_row_reg} < 32'(MAX_HEIGHT))
                     ? {23'd0, src_row_reg} : 32'(MAX_HEIGHT - 1);
    assign rd_addr   = rd_row * 32'(MAX_WIDTH) + rd_col;
    assign ram_we    = accept && (item.op == OP_LOAD) && load_ok;
    assign ram_en    = ram_we || (accept && (item.op == OP_EMIT));
    assign ram_addr  = (item.op == OP_LOAD) ? load_addr[AW-1:0] : rd_addr[AW-1:0];

    nnis_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.pixel_value[SW-1:0]),
        .rdata (ram_rdata)
    );

    // Output beat
    assign ch_eff = (channels_reg == '0) ? CH_W'(1)
                  : ((channels_reg > CH_LIMIT) ? CH_LIMIT : channels_reg);

    always_comb
    begin
        for (int b = 0; b < MAX_CHANNELS; b++)
        begin
            pix_mask[b*8 +: 8] = (CH_W'(b) < ch_eff) ? 8'hFF : 8'h00;
        end
    end

    assign result_valid        = emit_reg;
    assign result.pixel_out    = PIXEL_W'(ram_rdata & pix_mask);
    assign result.end_of_row   = eor_reg;
    assign result.end_of_frame = eof_reg;

    // Stepping arithmetic
    assign eor          = ({1'b0, out_col_reg} + 10'd1) >= {1'b0, frame_w_reg};
    assign eof          = eor && (({1'b0, out_row_reg} + 10'd1) >= {1'b0, frame_h_reg});
    assign col_err_dec  = (ERR_W+1)'(col_err_reg) - $signed({2'b00, col_rem_reg});
    assign row_err_dec  = (ERR_W+1)'(row_err_reg) - $signed({2'b00, row_rem_reg});
    assign div_col_step = div_step(div_col_reg, frame_w_reg);
    assign div_row_step = div_step(div_row_reg, frame_h_reg);

    // State machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        frame_w_next  = frame_w_reg;
        frame_h_next  = frame_h_reg;
        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        col_err_next  = col_err_reg;
        row_err_next  = row_err_reg;
        col_step_next = col_step_reg;
        row_step_next = row_step_reg;
        col_rem_next  = col_rem_reg;
        row_rem_next  = row_rem_reg;
        div_col_next  = div_col_reg;
        div_row_next  = div_row_reg;
        div_cnt_next  = div_cnt_reg;
        emit_next     = 1'b0;
        eor_next      = eor_reg;
        eof_next      = eof_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.op)
                        OP_RESTART:
                        begin
                            frame_w_next     = clamp_dim(dst_width_reg, W_LIMIT);
                            frame_h_next     = clamp_dim(dst_height_reg, H_LIMIT);
                            div_col_next.num = clamp_dim(src_width_reg, W_LIMIT);
                            div_col_next.rem = '0;
                            div_row_next.num = clamp_dim(src_height_reg, H_LIMIT);
                            div_row_next.rem = '0;
                            div_cnt_next     = CNT_W'(DIV_STEPS);
                            state_next       = ST_DIVIDE;
                        end
                        OP_EMIT:
                        begin
                            emit_next = 1'b1;
                            eor_next  = eor;
                            eof_next  = eof;
                            if (eof)
                            begin
                                src_col_next = '0;
                                src_row_next = '0;
                                out_col_next = '0;
                                out_row_next = '0;
                                col_err_next = $signed({1'b0, frame_w_reg});
                                row_err_next = $signed({1'b0, frame_h_reg});
                            end
                            else if (eor)
                            begin
                                out_col_next = '0;
                                src_col_next = '0;
                                col_err_next = $signed({1'b0, frame_w_reg});
                                out_row_next = out_row_reg + DIM_W'(1);
                                if (row_err_dec <= 0)
                                begin
                                    row_err_next = ERR_W'(row_err_dec
                                                 + $signed({2'b00, frame_h_reg}));
                                    src_row_next = src_row_reg + row_step_reg + DIM_W'(1);
                                end
                                else
                                begin
                                    row_err_next = ERR_W'(row_err_dec);
                                    src_row_next = src_row_reg + row_step_reg;
                                end
                            end
                            else
                            begin
                                out_col_next = out_col_reg + DIM_W'(1);
                                if (col_err_dec <= 0)
                                begin
                                    col_err_next = ERR_W'(col_err_dec
                                                 + $signed({2'b00, frame_w_reg}));
                                    src_col_next = src_col_reg + col_step_reg + DIM_W'(1);
                                end
                                else
                                begin
                                    col_err_next = ERR_W'(col_err_dec);
                                    src_col_next = src_col_reg + col_step_reg;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIVIDE:
            begin
                div_col_next = div_col_step;
                div_row_next = div_row_step;
                div_cnt_next = div_cnt_reg - CNT_W'(1);
                if (div_cnt_reg == CNT_W'(1))
                begin
                    col_step_next = div_col_step.num;
                    col_rem_next  = div_col_step.rem;
                    row_step_next = div_row_step.num;
                    row_rem_next  = div_row_step.rem;
                    src_col_next  = '0;
                    src_row_next  = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    col_err_next  = $signed({1'b0, frame_w_reg});
                    row_err_next  = $signed({1'b0, frame_h_reg});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_W'(256);
            src_height_reg <= DIM_W'(256);
            dst_width_reg  <= DIM_W'(256);
            dst_height_reg <= DIM_W'(256);
            channels_reg   <= CH_W'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                REG_CHANNELS:   channels_reg   <= cfg_data[CH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg  <= clamp_dim(DIM_W'(256), W_LIMIT);
            frame_h_reg  <= clamp_dim(DIM_W'(256), H_LIMIT);
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            col_err_reg  <= '0;
            row_err_reg  <= '0;
            col_step_reg <= '0;
            row_step_reg <= '0;
            col_rem_reg  <= '0;
            row_rem_reg  <= '0;
            div_cnt_reg  <= '0;
            emit_reg     <= 1'b0;
        end
        else
        begin
            frame_w_reg  <= frame_w_next;
            frame_h_reg  <= frame_h_next;
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            col_err_reg  <= col_err_next;
            row_err_reg  <= row_err_next;
            col_step_reg <= col_step_next;
            row_step_reg <= row_step_next;
            col_rem_reg  <= col_rem_next;
            row_rem_reg  <= row_rem_next;
            div_cnt_reg  <= div_cnt_next;
            emit_reg     <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_col_reg <= div_col_next;
        div_row_reg <= div_row_next;
        eor_reg     <= eor_next;
        eof_reg     <= eof_next;
    end

    a_result_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && item.op == OP_EMIT))
        else $error("result beat without an emit beat");

    a_eof_implies_eor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_frame |-> result.end_of_row)
        else $error("end of frame without end of row");

    a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.op == OP_RESTART |=> busy)
        else $error("restart did not start the divider");

    a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
        busy && div_cnt_reg == CNT_W'(1) |=> !busy && div_cnt_reg == '0)
        else $error("divider did not finish on its last step");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> div_cnt_reg == '0)
        else $error("divider count left over while idle");

endmodule

// ===== dv/nearest_neighbor_image_scaler_test.sv =====
// Self-checking testbench for nearest_neighbor_image_scaler: directed and random beats
// against an in-bench predictor of the frame store and the Bresenham stepping.
// Depends on nnis_pkg and the scaler RTL.
module nearest_neighbor_image_scaler_test;

    import nnis_pkg::*;

    localparam int STORE_SIDE   = 256;
    localparam int SETTLE_TICKS = 12;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int ITEM_TARGET  = 1750;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    item_t                  in_beat   = '0;
    logic                   result_valid;
    result_t                res_beat;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor state
    logic [PIXEL_W-1:0]       pixel_mem   [0:STORE_SIDE*STORE_SIDE-1];
    bit                       pixel_known [0:STORE_SIDE*STORE_SIDE-1];
    logic [DIM_W-1:0]         reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
    logic [CH_W-1:0]          reg_chan;
    logic [DIM_W-1:0]         rd_col, rd_row;
    logic [COORD_W-1:0]       px_col, px_row;
    logic signed [ERR_W-1:0]  col_acc, row_acc;
    logic [DIM_W-1:0]         col_inc, row_inc;
    logic [COORD_W-1:0]       col_frac, row_frac;
    logic [DIM_W-1:0]         out_w, out_h;
    result_t                  expected_pixels [$];

    int  mismatches   = 0;
    int  result_count = 0;
    int  items_sent   = 0;
    int  burst_left   = 0;
    bit  steady       = 1'b0;
    bit  sending      = 1'b0;

    nearest_neighbor_image_scaler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (in_beat),
        .result_valid (result_valid),
        .result       (res_beat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int clamp_size(logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > STORE_SIDE)
            return STORE_SIDE;
        return int'(v);
    endfunction

    function automatic logic [PIXEL_W-1:0] lane_mask();
        int c;
        c = int'(reg_chan);
        if (c < 1)
            c = 1;
        if (c > 4)
            c = 4;
        if (c == 4)
            return 32'hFFFF_FFFF;
        return (32'h1 << (8 * c)) - 32'h1;
    endfunction

    function automatic logic [15:0] fetch_addr();
        logic [7:0] c;
        logic [7:0] r;
        c = (rd_col < 9'd256) ? rd_col[7:0] : 8'hFF;
        r = (rd_row < 9'd256) ? rd_row[7:0] : 8'hFF;
        return {r, c};
    endfunction

    function automatic item_t rand_item(op_t op);
        item_t it;
        it.op          = op;
        it.load_col    = 8'($urandom);
        it.load_row    = 8'($urandom);
        it.pixel_value = $urandom;
        return it;
    endfunction

    function automatic logic [DIM_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return DIM_W'($urandom_range(1, 12));
        if (r < 17)
            return DIM_W'($urandom_range(1, 256));
        if (r == 17)
            return '0;
        if (r == 18)
            return DIM_W'($urandom_range(257, 511));
        return DIM_W'(256);
    endfunction

    task automatic reset_scaler_model();
        reg_src_w = 9'd256;
        reg_src_h = 9'd256;
        reg_dst_w = 9'd256;
        reg_dst_h = 9'd256;
        reg_chan  = 3'd3;
        rd_col    = '0;
        rd_row    = '0;
        px_col    = '0;
        px_row    = '0;
        col_acc   = '0;
        row_acc   = '0;
        col_inc   = '0;
        row_inc   = '0;
        col_frac  = '0;
        row_frac  = '0;
        out_w     = 9'd256;
        out_h     = 9'd256;
    endtask

    task automatic begin_frame();
        rd_col  = '0;
        rd_row  = '0;
        px_col  = '0;
        px_row  = '0;
        col_acc = ERR_W'(out_w);
        row_acc = ERR_W'(out_h);
    endtask

    task automatic apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SRC_WIDTH:  reg_src_w = data;
            REG_SRC_HEIGHT: reg_src_h = data;
            REG_DST_WIDTH:  reg_dst_w = data;
            REG_DST_HEIGHT: reg_dst_h = data;
            REG_CHANNELS:   reg_chan  = data[CH_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic step_scaler(item_t it);
        result_t    want;
        logic [15:0] a;
        int         sw;
        int         sh;
        int         acc;
        case (it.op)
            OP_LOAD:
            begin
                a = {it.load_row, it.load_col};
                pixel_mem[a]   = it.pixel_value;
                pixel_known[a] = 1'b1;
            end
            OP_RESTART:
            begin
                sw       = clamp_size(reg_src_w);
                sh       = clamp_size(reg_src_h);
                out_w    = DIM_W'(clamp_size(reg_dst_w));
                out_h    = DIM_W'(clamp_size(reg_dst_h));
                col_inc  = DIM_W'(sw / int'(out_w));
                col_frac = COORD_W'(sw % int'(out_w));
                row_inc  = DIM_W'(sh / int'(out_h));
                row_frac = COORD_W'(sh % int'(out_h));
                begin_frame();
            end
            OP_EMIT:
            begin
                a = fetch_addr();
                want.pixel_out    = pixel_mem[a] & lane_mask();
                want.end_of_row   = (int'(px_col) + 1 >= int'(out_w));
                want.end_of_frame = want.end_of_row && (int'(px_row) + 1 >= int'(out_h));
                expected_pixels.push_back(want);
                if (want.end_of_frame)
                    begin_frame();
                else if (want.end_of_row)
                begin
                    px_col  = '0;
                    rd_col  = '0;
                    col_acc = ERR_W'(out_w);
                    px_row  = px_row + 8'd1;
                    rd_row  = rd_row + row_inc;
                    acc     = int'(row_acc) - int'(row_frac);
                    if (acc <= 0)
                    begin
                        acc    = acc + int'(out_h);
                        rd_row = rd_row + 9'd1;
                    end
                    row_acc = ERR_W'(acc);
                end
                else
                begin
                    px_col = px_col + 8'd1;
                    rd_col = rd_col + col_inc;
                    acc    = int'(col_acc) - int'(col_frac);
                    if (acc <= 0)
                    begin
                        acc    = acc + int'(out_w);
                        rd_col = rd_col + 9'd1;
                    end
                    col_acc = ERR_W'(acc);
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH: %s", msg);
    endtask

    task automatic drop_start();
        if (sending)
        begin
            start   <= 1'b0;
            sending = 1'b0;
        end
    endtask

    task automatic pace_sender();
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                drop_start();
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_item(item_t it);
        start   <= 1'b1;
        sending = 1'b1;
        in_beat <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        step_scaler(it);
        items_sent++;
        pace_sender();
    endtask

    task automatic send_load(logic [7:0] col, logic [7:0] row, logic [31:0] value);
        item_t it;
        it             = rand_item(OP_LOAD);
        it.load_col    = col;
        it.load_row    = row;
        it.pixel_value = value;
        send_item(it);
    endtask

    // Fill the entry the next emit reads if it was never written.
    task automatic emit_pixel();
        logic [15:0] a;
        a = fetch_addr();
        if (!pixel_known[a])
            send_load(a[7:0], a[15:8], $urandom);
        send_item(rand_item(OP_EMIT));
    endtask

    task automatic settle_block();
        drop_start();
        while (expected_pixels.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(logic [8:0] sw, logic [8:0] sh, logic [8:0] dw,
                                logic [8:0] dh, logic [8:0] ch);
        settle_block();
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_CHANNELS, ch);
    endtask

    task automatic run_frame(logic [8:0] sw, logic [8:0] sh, logic [8:0] dw,
                             logic [8:0] dh, logic [8:0] ch);
        int n;
        program_regs(sw, sh, dw, dh, ch);
        steady = ($urandom_range(0, 2) == 0);
        send_item(rand_item(OP_RESTART));
        n = int'(out_w) * int'(out_h) + 2;
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
                send_load(8'($urandom), 8'($urandom), $urandom);
            emit_pixel();
        end
        steady = 1'b0;
    endtask

    task automatic test_reset_state();
        repeat (4) emit_pixel();
    endtask

    task automatic test_store_extremes();
        program_regs(9'd2, 9'd2, 9'd2, 9'd2, 9'd4);
        send_load(8'd0, 8'd0, 32'hFFFF_FFFF);
        send_load(8'd1, 8'd0, 32'h0000_0000);
        send_load(8'd0, 8'd1, 32'hAAAA_AAAA);
        send_load(8'd1, 8'd1, 32'h5555_5555);
        send_load(8'd255, 8'd255, 32'h8000_0001);
        send_load(8'd255, 8'd0, 32'h7FFF_FFFE);
        send_load(8'd0, 8'd255, 32'hC3C3_3C3C);
        send_item(rand_item(OP_RESTART));
        repeat (5) emit_pixel();
    endtask

    task automatic test_unknown_op();
        item_t it;
        it             = rand_item(OP_NOP);
        it.load_col    = 8'hFF;
        it.load_row    = 8'hFF;
        it.pixel_value = 32'hFFFF_FFFF;
        send_item(it);
        it.load_col    = 8'h00;
        it.load_row    = 8'h00;
        it.pixel_value = 32'h0000_0000;
        send_item(it);
        emit_pixel();
    endtask

    task automatic test_frame_sizes();
        run_frame(9'd1, 9'd1, 9'd1, 9'd1, 9'd1);
        run_frame(9'd256, 9'd256, 9'd256, 9'd1, 9'd4);
        run_frame(9'd256, 9'd256, 9'd1, 9'd256, 9'd2);
        run_frame(9'd1, 9'd1, 9'd40, 9'd1, 9'd3);
        run_frame(9'd0, 9'd511, 9'd3, 9'd0, 9'd0);
        run_frame(9'd511, 9'd0, 9'd0, 9'd511, 9'd7);
        run_frame(9'd7, 9'd13, 9'd3, 9'd5, 9'd2);
        run_frame(9'd3, 9'd5, 9'd7, 9'd11, 9'd3);
    endtask

    task automatic shuffle_config();
        settle_block();
        for (int i = 0; i < 5; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                if (i == REG_CHANNELS)
                    write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom_range(0, 511)));
                else
                    write_reg(CFG_INDEX_W'(i), pick_size());
            end
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
        if ($urandom_range(0, 7) != 0)
            send_item(rand_item(OP_RESTART));
    endtask

    task automatic test_random_traffic();
        int pick;
        while (items_sent < ITEM_TARGET)
        begin
            shuffle_config();
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(40, 160))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    emit_pixel();
                else if (pick < 85)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_load(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                                  $urandom);
                    else
                        send_load(8'($urandom), 8'($urandom), $urandom);
                end
                else if (pick < 93)
                    send_item(rand_item(OP_RESTART));
                else
                    send_item(rand_item(OP_NOP));
                if (items_sent % 400 == 200)
                    settle_block();
            end
            steady = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            result_count++;
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          result_count));
            else
            begin
                want = expected_pixels.pop_front();
                if (res_beat.pixel_out !== want.pixel_out)
                    report_mismatch($sformatf("result %0d pixel_out %h, expected %h",
                                              result_count, res_beat.pixel_out,
                                              want.pixel_out));
                if (res_beat.end_of_row !== want.end_of_row)
                    report_mismatch($sformatf("result %0d end_of_row %b, expected %b",
                                              result_count, res_beat.end_of_row,
                                              want.end_of_row));
                if (res_beat.end_of_frame !== want.end_of_frame)
                    report_mismatch($sformatf("result %0d end_of_frame %b, expected %b",
                                              result_count, res_beat.end_of_frame,
                                              want.end_of_frame));
            end
        end
    end

    initial
    begin
        reset_scaler_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_store_extremes();
        test_unknown_op();
        test_frame_sizes();
        test_random_traffic();
        settle_block();
        if (mismatches == 0)
            $display("nearest_neighbor_image_scaler verification clean");
        else
            $display("nearest_neighbor_image_scaler verification failed");
        $finish;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("nearest_neighbor_image_scaler verification failed");
        $finish;
    end

endmodule
